@@ hdl/lzwtd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwtd_pkg: shared types and constants of the LZW trie dictionary
// Operation codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package lzwtd_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int MIN_CODE_BITS     = 9;
  localparam int ROOT_COUNT        = 256;
  localparam int BYTE_W            = 8;
  localparam int CFG_W             = 4;
  localparam int CODE_BITS_RST     = 12;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Source of the shared table read address
  typedef enum logic [2:0] {
    RD_HOLD,
    RD_PREFIX,
    RD_ENTRY,
    RD_HEAD,
    RD_SIB
  } rd_sel_t;

  // Kind of result loaded into the output register
  typedef enum logic [2:0] {
    RES_NULL,
    RES_BYTE,
    RES_FOUND,
    RES_NEW,
    RES_READ,
    RES_CLEAR
  } res_sel_t;

  typedef struct packed {
    logic     load;
    rd_sel_t  rd_sel;
    logic     link_head;
    logic     link_sib;
    logic     append;
    logic     clear;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic has_prefix;
    logic full;
    logic prefix_ok;
    logic head_none;
    logic match;
    logic sib_none;
  } sts_t;

endpackage

@@ hdl/lzwtd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzwtd_ctrl: operation sequencer of the LZW trie dictionary
// Steps one request through dispatch, child head read, sibling walk,
// link and append, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lzwtd_ctrl
  import lzwtd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_HEAD_CHK,
    S_WALK,
    S_LINK,
    S_APPEND,
    S_FINISH
  } state_t;

  state_t   state, state_next;
  logic     link_sib, link_sib_next;
  res_sel_t res_sel, res_sel_next;
  logic     out_free;
  logic     is_insert;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign is_insert = (sts.op == OP_INSERT);

  // Decode state into commands and next state
  always_comb begin
    state_next    = state;
    link_sib_next = link_sib;
    res_sel_next  = res_sel;
    cmd           = '0;
    cmd.rd_sel    = RD_HOLD;
    cmd.res_sel   = res_sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        if (sts.op == OP_CLEAR) begin
          cmd.clear    = 1'b1;
          res_sel_next = RES_CLEAR;
        end else if (sts.op == OP_READ) begin
          cmd.rd_sel   = RD_ENTRY;
          res_sel_next = RES_READ;
        end else if (is_insert && sts.full) begin
          res_sel_next = RES_NULL;
        end else if (!sts.has_prefix) begin
          res_sel_next = RES_BYTE;
        end else if (!sts.prefix_ok) begin
          res_sel_next = RES_NULL;
        end else begin
          cmd.rd_sel = RD_PREFIX;
          state_next = S_HEAD_CHK;
        end
      end
      S_HEAD_CHK: begin
        if (sts.head_none) begin
          if (is_insert) begin
            link_sib_next = 1'b0;
            state_next    = S_LINK;
          end else begin
            res_sel_next = RES_NULL;
            state_next   = S_FINISH;
          end
        end else begin
          cmd.rd_sel = RD_HEAD;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.match) begin
          res_sel_next = RES_FOUND;
          state_next   = S_FINISH;
        end else if (sts.sib_none) begin
          if (is_insert) begin
            link_sib_next = 1'b1;
            state_next    = S_LINK;
          end else begin
            res_sel_next = RES_NULL;
            state_next   = S_FINISH;
          end
        end else begin
          cmd.rd_sel = RD_SIB;
        end
      end
      S_LINK: begin
        cmd.link_head = !link_sib;
        cmd.link_sib  = link_sib;
        state_next    = S_APPEND;
      end
      S_APPEND: begin
        cmd.append   = 1'b1;
        res_sel_next = RES_NEW;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, walk flags and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      link_sib  <= 1'b0;
      res_sel   <= RES_NULL;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      link_sib <= link_sib_next;
      res_sel  <= res_sel_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/lzwtd_dpath.sv @@
// ----------------------------------------------------------------------------
// lzwtd_dpath: tables and registers of the LZW trie dictionary
// Parent, byte, child head and sibling tables, root child valid bits,
// entry count, width register and the output register.
// ----------------------------------------------------------------------------
module lzwtd_dpath
  import lzwtd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [1:0]               operation,
  input  logic                     has_prefix,
  input  logic [MAX_CODE_BITS-1:0] prefix_code,
  input  logic [BYTE_W-1:0]        next_byte,
  input  logic [MAX_CODE_BITS-1:0] entry_code,
  input  logic                     cfg_write,
  input  logic [CFG_W-1:0]         code_bits,
  output logic [MAX_CODE_BITS-1:0] code,
  output logic                     code_valid,
  output logic [BYTE_W-1:0]        entry_byte,
  output logic                     entry_has_parent,
  output logic [MAX_CODE_BITS-1:0] entry_parent,
  output logic [MAX_CODE_BITS:0]   entries_used
);

  localparam int CW    = MAX_CODE_BITS;
  localparam int LW    = CW + 1;
  localparam int DEPTH = 1 << CW;
  localparam int BW    = $clog2(MAX_CODE_BITS + 1);

  localparam logic [LW-1:0] LINK_NONE = {1'b1, {CW{1'b0}}};

  // Captured request
  op_t               op_q;
  logic              has_prefix_q;
  logic [CW-1:0]     prefix_q;
  logic [BYTE_W-1:0] nb_q;
  logic [CW-1:0]     ecode_q;

  logic [CFG_W-1:0]      code_bits_q;
  logic [CW-1:0]         count;
  logic [ROOT_COUNT-1:0] root_vld;

  // Tables
  logic [CW-1:0]     parent_mem [DEPTH];
  logic [BYTE_W-1:0] byte_mem   [DEPTH];
  logic [LW-1:0]     child_mem  [DEPTH];
  logic [LW-1:0]     sib_mem    [DEPTH];

  logic [CW-1:0]     parent_rd;
  logic [BYTE_W-1:0] byte_rd;
  logic [LW-1:0]     child_rd;
  logic [LW-1:0]     sib_rd;

  logic [CW-1:0] rd_addr;
  logic [CW-1:0] last_addr;
  logic [BW-1:0] width_clamp;
  logic [CW-1:0] limit;
  logic          prefix_root;
  logic          ecode_root;

  logic          child_we;
  logic [CW-1:0] child_waddr;
  logic [LW-1:0] child_wdata;
  logic          sib_we;
  logic [CW-1:0] sib_waddr;
  logic [LW-1:0] sib_wdata;

  // Clamp the code width and form the table limit
  always_comb begin
    if (code_bits_q < CFG_W'(MIN_CODE_BITS)) begin
      width_clamp = BW'(MIN_CODE_BITS);
    end else if (32'(code_bits_q) > MAX_CODE_BITS) begin
      width_clamp = BW'(MAX_CODE_BITS);
    end else begin
      width_clamp = BW'(code_bits_q);
    end
  end

  assign limit       = ~({CW{1'b1}} << width_clamp);
  assign prefix_root = (prefix_q < CW'(ROOT_COUNT));
  assign ecode_root  = (ecode_q < CW'(ROOT_COUNT));

  // Select the shared read address
  always_comb begin
    case (cmd.rd_sel)
      RD_PREFIX: rd_addr = prefix_q;
      RD_ENTRY:  rd_addr = ecode_q;
      RD_HEAD:   rd_addr = child_rd[CW-1:0];
      RD_SIB:    rd_addr = sib_rd[CW-1:0];
      default:   rd_addr = last_addr;
    endcase
  end

  // Report conditions to the controller
  always_comb begin
    sts.op         = op_q;
    sts.has_prefix = has_prefix_q;
    sts.full       = (count >= limit);
    sts.prefix_ok  = (prefix_q < count);
    sts.head_none  = prefix_root ? !root_vld[prefix_q[BYTE_W-1:0]] : child_rd[CW];
    sts.match      = (byte_rd == nb_q);
    sts.sib_none   = sib_rd[CW];
  end

  // Capture the request and track the node being read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q         <= op_t'(operation);
      has_prefix_q <= has_prefix;
      prefix_q     <= prefix_code;
      nb_q         <= next_byte;
      ecode_q      <= entry_code;
    end
    last_addr <= rd_addr;
  end

  // Hold width, entry count and root child valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits_q <= CFG_W'(CODE_BITS_RST);
      count       <= CW'(ROOT_COUNT);
      root_vld    <= '0;
    end else begin
      if (cfg_write) begin
        code_bits_q <= code_bits;
      end
      if (cmd.clear) begin
        count    <= CW'(ROOT_COUNT);
        root_vld <= '0;
      end else begin
        if (cmd.append) begin
          count <= count + 1'b1;
        end
        if (cmd.link_head && prefix_root) begin
          root_vld[prefix_q[BYTE_W-1:0]] <= 1'b1;
        end
      end
    end
  end

  // Parent and byte tables: written on append
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      parent_mem[count] <= prefix_q;
      byte_mem[count]   <= nb_q;
    end
    parent_rd <= parent_mem[rd_addr];
    byte_rd   <= byte_mem[rd_addr];
  end

  // Child head table: link the prefix or clear the new entry
  assign child_we    = cmd.link_head || cmd.append;
  assign child_waddr = cmd.append ? count : prefix_q;
  assign child_wdata = cmd.append ? LINK_NONE : {1'b0, count};

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    child_rd <= child_mem[rd_addr];
  end

  // Sibling table: link the chain tail or clear the new entry
  assign sib_we    = cmd.link_sib || cmd.append;
  assign sib_waddr = cmd.append ? count : last_addr;
  assign sib_wdata = cmd.append ? LINK_NONE : {1'b0, count};

  always_ff @(posedge clk) begin
    if (sib_we) begin
      sib_mem[sib_waddr] <= sib_wdata;
    end
    sib_rd <= sib_mem[rd_addr];
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      code             <= '0;
      code_valid       <= 1'b0;
      entry_byte       <= '0;
      entry_has_parent <= 1'b0;
      entry_parent     <= '0;
      entries_used     <= {1'b0, count};
      case (cmd.res_sel)
        RES_BYTE: begin
          code       <= CW'(nb_q);
          code_valid <= 1'b1;
        end
        RES_FOUND: begin
          code       <= last_addr;
          code_valid <= 1'b1;
        end
        RES_NEW: begin
          code       <= count - 1'b1;
          code_valid <= 1'b1;
        end
        RES_READ: begin
          code <= ecode_q;
          if (ecode_q < count) begin
            code_valid <= 1'b1;
            if (ecode_root) begin
              entry_byte <= ecode_q[BYTE_W-1:0];
            end else begin
              entry_byte       <= byte_rd;
              entry_has_parent <= 1'b1;
              entry_parent     <= parent_rd;
            end
          end
        end
        RES_CLEAR: begin
          code       <= limit;
          code_valid <= 1'b1;
        end
        default: begin
          code_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hdl/lzw_trie_dictionary.sv @@
// ----------------------------------------------------------------------------
// lzw_trie_dictionary: LZW string dictionary in a child/sibling trie
// Lookup, insert, read-entry and clear over fixed code tables.
//
//   Channel   Direction  Handshake        Payload
//   in        to block   in_valid/stall   operation, has_prefix, prefix_code,
//                                         next_byte, entry_code
//   out       from block out_valid/stall  code, code_valid, entry_byte,
//                                         entry_has_parent, entry_parent,
//                                         entries_used
//   cfg       to block   cfg_valid/ready  code_bits
//
// One request at a time. Read-entry, clear and requests settled without a
// walk go from dispatch to finish; lookup and insert read the child head,
// then visit sibling nodes one per cycle through the registered table read;
// an insert that appends a new code adds the link and append states.
// Reset is synchronous; it restores 256 root codes and width 12 at once.
// A stalled result waits in the output register; the next request is taken
// as soon as the result has been loaded there.
// ----------------------------------------------------------------------------
module lzw_trie_dictionary
  import lzwtd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic                     has_prefix,
  input  logic [MAX_CODE_BITS-1:0] prefix_code,
  input  logic [BYTE_W-1:0]        next_byte,
  input  logic [MAX_CODE_BITS-1:0] entry_code,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MAX_CODE_BITS-1:0] code,
  output logic                     code_valid,
  output logic [BYTE_W-1:0]        entry_byte,
  output logic                     entry_has_parent,
  output logic [MAX_CODE_BITS-1:0] entry_parent,
  output logic [MAX_CODE_BITS:0]   entries_used,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         code_bits
);

  cmd_t cmd;
  sts_t sts;

  // Width register takes a write in any cycle
  assign cfg_ready = 1'b1;

  lzwtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzwtd_dpath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .operation        (operation),
    .has_prefix       (has_prefix),
    .prefix_code      (prefix_code),
    .next_byte        (next_byte),
    .entry_code       (entry_code),
    .cfg_write        (cfg_valid && cfg_ready),
    .code_bits        (code_bits),
    .code             (code),
    .code_valid       (code_valid),
    .entry_byte       (entry_byte),
    .entry_has_parent (entry_has_parent),
    .entry_parent     (entry_parent),
    .entries_used     (entries_used)
  );

endmodule

@@ verif/tb_lzw_trie_dictionary.sv @@
// ----------------------------------------------------------------------------
// tb_lzw_trie_dictionary: self-checking bench for the LZW trie dictionary
// A table of directed requests covers the roots, unused codes, empty and
// unknown prefixes, sibling walks, read-back and clear. Random phases follow:
// they run at several code widths, including a width below the fill level,
// and mostly grow encoder-like strings. Each result is checked field by field
// against the bench's behavioral trie model or a directed row's typed expectation.
// ----------------------------------------------------------------------------
module tb_lzw_trie_dictionary;
  import lzwtd_pkg::*;

  localparam int CW          = MAX_CODE_BITS_DEF;
  localparam int TBL         = 1 << CW;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 8;

  localparam logic [CW:0] NO_LINK = {1'b1, {CW{1'b0}}};

  typedef struct packed {
    op_t             op;
    logic            has_prefix;
    logic [CW-1:0]   prefix;
    logic [7:0]      nbyte;
    logic [CW-1:0]   ecode;
  } dict_request_t;

  typedef struct packed {
    logic [CW-1:0]   code;
    logic            code_valid;
    logic [7:0]      entry_byte;
    logic            entry_has_parent;
    logic [CW-1:0]   entry_parent;
    logic [CW:0]     entries_used;
  } dict_result_t;

  typedef struct packed {
    dict_request_t   req;
    logic            typed;
    dict_result_t    exp;
  } directed_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      operation = OP_LOOKUP;
  logic            has_prefix = 1'b0;
  logic [CW-1:0]   prefix_code = '0;
  logic [7:0]      next_byte = '0;
  logic [CW-1:0]   entry_code = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CW-1:0]   code;
  logic            code_valid;
  logic [7:0]      entry_byte;
  logic            entry_has_parent;
  logic [CW-1:0]   entry_parent;
  logic [CW:0]     entries_used;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [3:0]      code_bits = 4'd0;

  lzw_trie_dictionary u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .has_prefix       (has_prefix),
    .prefix_code      (prefix_code),
    .next_byte        (next_byte),
    .entry_code       (entry_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .code             (code),
    .code_valid       (code_valid),
    .entry_byte       (entry_byte),
    .entry_has_parent (entry_has_parent),
    .entry_parent     (entry_parent),
    .entries_used     (entries_used),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .code_bits        (code_bits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Trie model state
  logic [CW:0]     parent_link  [TBL];
  logic [7:0]      node_byte    [TBL];
  logic [CW:0]     first_child  [TBL];
  logic [CW:0]     next_sibling [TBL];
  int unsigned     used_count;
  logic [3:0]      width_reg;
  int unsigned     last_code;

  dict_result_t    expected_results [$];
  int              mismatches = 0;
  int              idle_cycles = 0;
  int              burst_left;
  int              stall_mode = 0;
  int              mode_left = 0;

  // Directed requests; typed expectations only where obvious
  directed_row_t directed_rows [25] = '{
    '{'{OP_READ,   1'b0, 12'd0,    8'd0,   12'd0},    1'b1, '{12'd0,    1'b1, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_READ,   1'b0, 12'd0,    8'd0,   12'd255},  1'b1, '{12'd255,  1'b1, 8'd255, 1'b0, 12'd0,  13'd256}},
    '{'{OP_READ,   1'b0, 12'd0,    8'd0,   12'd256},  1'b1, '{12'd256,  1'b0, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_READ,   1'b1, 12'hFFF,  8'hFF,  12'd4095}, 1'b1, '{12'd4095, 1'b0, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_LOOKUP, 1'b0, 12'hFFF,  8'hAB,  12'd0},    1'b1, '{12'd171,  1'b1, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_LOOKUP, 1'b1, 12'd65,   8'd66,  12'd0},    1'b1, '{12'd0,    1'b0, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_LOOKUP, 1'b1, 12'd4095, 8'd0,   12'd0},    1'b1, '{12'd0,    1'b0, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_INSERT, 1'b1, 12'd65,   8'd66,  12'd0},    1'b1, '{12'd256,  1'b1, 8'd0,   1'b0, 12'd0,  13'd257}},
    '{'{OP_INSERT, 1'b1, 12'd65,   8'd66,  12'd0},    1'b1, '{12'd256,  1'b1, 8'd0,   1'b0, 12'd0,  13'd257}},
    '{'{OP_INSERT, 1'b1, 12'd65,   8'd67,  12'd0},    1'b1, '{12'd257,  1'b1, 8'd0,   1'b0, 12'd0,  13'd258}},
    '{'{OP_INSERT, 1'b1, 12'd65,   8'd68,  12'd0},    1'b1, '{12'd258,  1'b1, 8'd0,   1'b0, 12'd0,  13'd259}},
    '{'{OP_LOOKUP, 1'b1, 12'd65,   8'd68,  12'd0},    1'b0, '0},
    '{'{OP_LOOKUP, 1'b1, 12'd65,   8'd67,  12'd0},    1'b0, '0},
    '{'{OP_LOOKUP, 1'b1, 12'd65,   8'd0,   12'd0},    1'b0, '0},
    '{'{OP_INSERT, 1'b1, 12'd256,  8'd0,   12'd0},    1'b1, '{12'd259,  1'b1, 8'd0,   1'b0, 12'd0,  13'd260}},
    '{'{OP_READ,   1'b0, 12'd0,    8'd0,   12'd259},  1'b0, '0},
    '{'{OP_READ,   1'b0, 12'd0,    8'd0,   12'd256},  1'b1, '{12'd256,  1'b1, 8'd66,  1'b1, 12'd65, 13'd260}},
    '{'{OP_INSERT, 1'b0, 12'd0,    8'd255, 12'd0},    1'b1, '{12'd255,  1'b1, 8'd0,   1'b0, 12'd0,  13'd260}},
    '{'{OP_INSERT, 1'b1, 12'd4095, 8'd255, 12'd0},    1'b1, '{12'd0,    1'b0, 8'd0,   1'b0, 12'd0,  13'd260}},
    '{'{OP_INSERT, 1'b1, 12'd260,  8'd1,   12'd0},    1'b1, '{12'd0,    1'b0, 8'd0,   1'b0, 12'd0,  13'd260}},
    '{'{OP_LOOKUP, 1'b0, 12'd0,    8'd0,   12'd0},    1'b1, '{12'd0,    1'b1, 8'd0,   1'b0, 12'd0,  13'd260}},
    '{'{OP_LOOKUP, 1'b1, 12'd0,    8'd255, 12'd0},    1'b0, '0},
    '{'{OP_CLEAR,  1'b0, 12'd0,    8'd0,   12'd0},    1'b1, '{12'd4095, 1'b1, 8'd0,   1'b0, 12'd0,  13'd256}},
    '{'{OP_LOOKUP, 1'b1, 12'd65,   8'd66,  12'd0},    1'b0, '0},
    '{'{OP_READ,   1'b0, 12'd0,    8'd0,   12'd256},  1'b1, '{12'd256,  1'b0, 8'd0,   1'b0, 12'd0,  13'd256}}
  };

  // Table limit and reset code for the current width
  function automatic int unsigned code_limit();
    int unsigned w;
    w = width_reg;
    if (w < MIN_CODE_BITS) w = MIN_CODE_BITS;
    if (w > CW) w = CW;
    return (1 << w) - 1;
  endfunction

  function automatic void restore_roots();
    for (int i = 0; i < ROOT_COUNT; i++) begin
      parent_link[i]  = NO_LINK;
      node_byte[i]    = i[7:0];
      first_child[i]  = NO_LINK;
      next_sibling[i] = NO_LINK;
    end
    used_count = ROOT_COUNT;
  endfunction

  // Apply one request to the trie model and return its result
  function automatic dict_result_t predict_dictionary_result(input dict_request_t req);
    dict_result_t res;
    logic [CW:0]  idx;
    logic [CW:0]  nxt;
    int           steps;
    bit           found;
    int unsigned  nc;
    res = '0;
    case (req.op)
      OP_LOOKUP: begin
        if (!req.has_prefix) begin
          res.code = CW'(req.nbyte);
          res.code_valid = 1'b1;
        end else if (req.prefix < used_count) begin
          idx = first_child[req.prefix];
          steps = 0;
          while (!idx[CW] && steps < TBL) begin
            if (node_byte[idx[CW-1:0]] == req.nbyte) begin
              res.code = idx[CW-1:0];
              res.code_valid = 1'b1;
              break;
            end
            idx = next_sibling[idx[CW-1:0]];
            steps++;
          end
        end
      end
      OP_INSERT: begin
        if (used_count >= code_limit()) begin
          // table full: leave everything as is
        end else if (!req.has_prefix) begin
          res.code = CW'(req.nbyte);
          res.code_valid = 1'b1;
        end else if (req.prefix < used_count) begin
          nc = used_count;
          found = 1'b0;
          idx = first_child[req.prefix];
          if (idx[CW]) begin
            first_child[req.prefix] = {1'b0, nc[CW-1:0]};
          end else begin
            steps = 0;
            forever begin
              if (node_byte[idx[CW-1:0]] == req.nbyte) begin
                found = 1'b1;
                break;
              end
              nxt = next_sibling[idx[CW-1:0]];
              if (nxt[CW] || steps >= TBL) break;
              idx = nxt;
              steps++;
            end
            if (found) begin
              res.code = idx[CW-1:0];
              res.code_valid = 1'b1;
            end else begin
              next_sibling[idx[CW-1:0]] = {1'b0, nc[CW-1:0]};
            end
          end
          if (!found) begin
            parent_link[nc]  = {1'b0, req.prefix};
            node_byte[nc]    = req.nbyte;
            first_child[nc]  = NO_LINK;
            next_sibling[nc] = NO_LINK;
            used_count = nc + 1;
            res.code = nc[CW-1:0];
            res.code_valid = 1'b1;
          end
        end
      end
      OP_READ: begin
        res.code = req.ecode;
        if (req.ecode < used_count) begin
          res.code_valid = 1'b1;
          res.entry_byte = node_byte[req.ecode];
          if (!parent_link[req.ecode][CW]) begin
            res.entry_has_parent = 1'b1;
            res.entry_parent = parent_link[req.ecode][CW-1:0];
          end
        end
      end
      default: begin
        restore_roots();
        res.code = CW'(code_limit());
        res.code_valid = 1'b1;
      end
    endcase
    if ((req.op == OP_LOOKUP || req.op == OP_INSERT) && res.code_valid) last_code = res.code;
    res.entries_used = used_count[CW:0];
    return res;
  endfunction

  // Insert idle gaps between bursts of requests
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Drive one request, hold it until taken, then record its expected result
  task automatic send_request(input dict_request_t req, input bit typed,
                              input dict_result_t typed_exp);
    dict_result_t predicted;
    pace_sender();
    in_valid    <= 1'b1;
    operation   <= req.op;
    has_prefix  <= req.has_prefix;
    prefix_code <= req.prefix;
    next_byte   <= req.nbyte;
    entry_code  <= req.ecode;
    do @(posedge clk); while (in_stall);
    predicted = predict_dictionary_result(req);
    expected_results.push_back(typed ? typed_exp : predicted);
  endtask

  // Write the width register once the block has drained
  task automatic write_code_bits(input logic [3:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    code_bits <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = value;
  endtask

  function automatic logic [7:0] pick_byte();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'(97 + $urandom_range(7));
  endfunction

  // Mostly extend recent strings; sometimes start at a root or go astray
  function automatic logic [CW-1:0] pick_prefix();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return (last_code < used_count) ? last_code[CW-1:0] : CW'(97);
      5, 6, 7:       return CW'(97 + $urandom_range(7));
      8:             return CW'($urandom_range(used_count - 1));
      default:       return CW'($urandom_range(TBL - 1));
    endcase
  endfunction

  task automatic run_random_phase(input int count, input int ins_pct, input int clear_div);
    dict_request_t req;
    int            pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      req.has_prefix = ($urandom_range(11) != 0);
      req.prefix     = pick_prefix();
      req.nbyte      = pick_byte();
      req.ecode      = ($urandom_range(9) < 7) ? CW'($urandom_range(used_count - 1))
                                               : CW'($urandom_range(TBL - 1));
      if (clear_div > 0 && $urandom_range(clear_div - 1) == 0) req.op = OP_CLEAR;
      else if (pick < ins_pct) req.op = OP_INSERT;
      else if (pick < ins_pct + 25) req.op = OP_LOOKUP;
      else req.op = OP_READ;
      send_request(req, 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    burst_left = 0;
    last_code  = 97;
    width_reg  = CODE_BITS_RST;
    restore_roots();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_code_bits(4'd12);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].exp);
    end

    // Grow, fill narrowest, widen, shrink below the fill level, regrow with clears
    write_code_bits(4'd12);
    run_random_phase(250, 55, 0);
    write_code_bits(4'd9);
    run_random_phase(250, 60, 0);
    write_code_bits(4'd15);
    run_random_phase(250, 55, 0);
    write_code_bits(4'd0);
    run_random_phase(250, 50, 80);
    write_code_bits(4'd10);
    run_random_phase(250, 50, 100);
    write_code_bits(4'd11);
    run_random_phase(250, 50, 100);
    write_code_bits(4'd12);
    run_random_phase(250, 45, 60);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver stall pattern: free-running, light or heavy, in random stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(3) == 0);
        default: out_stall <= ($urandom_range(3) != 0);
      endcase
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    dict_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: code=%0d used=%0d",
                                       code, entries_used);
      end else begin
        exp = expected_results.pop_front();
        if (code !== exp.code || code_valid !== exp.code_valid ||
            entry_byte !== exp.entry_byte || entry_has_parent !== exp.entry_has_parent ||
            entry_parent !== exp.entry_parent || entries_used !== exp.entries_used) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp code=%0d vld=%0d byte=%0d hasp=%0d par=%0d used=%0d",
                     exp.code, exp.code_valid, exp.entry_byte, exp.entry_has_parent,
                     exp.entry_parent, exp.entries_used);
            $display("          got code=%0d vld=%0d byte=%0d hasp=%0d par=%0d used=%0d",
                     code, code_valid, entry_byte, entry_has_parent,
                     entry_parent, entries_used);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
